// ----- rtl/core/http_byte_range_parser_macros.svh -----
// Assertion macros shared by the byte-range parser.
`ifndef HTTP_BYTE_RANGE_PARSER_MACROS_SVH
`define HTTP_BYTE_RANGE_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define HBR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define HBR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HBR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define HBR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/core/hbr_pkg.sv -----
package hbr_pkg;

  localparam int RES_W = 48;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_SYNTAX = 2'd2;
  localparam logic [1:0] ST_UNSAT  = 2'd3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic       kind;
    logic [7:0] character;
  } hbr_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [RES_W-1:0] range_start;
    logic [RES_W-1:0] range_end;
    logic             multipart;
    logic             final_res;
  } hbr_res_t;

endpackage

// ----- rtl/core/hbr_parse.sv -----
module hbr_parse #(
  parameter int POS_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  hbr_pkg::hbr_item_t    item,
  input  logic [POS_BITS-1:0]   file_size,
  output logic                  res_valid,
  output hbr_pkg::hbr_res_t     res
);

  localparam int RW    = hbr_pkg::RES_W;
  localparam int ACC_W = POS_BITS + 4;

  typedef enum logic [2:0] {
    PH_START,
    PH_SUFFIX,
    PH_SPAN,
    PH_JUNK,
    PH_FAIL
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [POS_BITS-1:0] first_r, first_nxt;
  logic [POS_BITS-1:0] second_r, second_nxt;
  logic                digit_seen_r, digit_seen_nxt;
  logic                list_seen_r, list_seen_nxt;
  logic                range_seen_r, range_seen_nxt;
  logic [1:0]          err_r, err_nxt;

  logic                is_digit;
  logic                is_space;
  logic [POS_BITS-1:0] acc_in;
  logic [ACC_W-1:0]    acc_ext;
  logic [ACC_W-1:0]    acc_wide;
  logic [POS_BITS-1:0] acc_out;

  logic [POS_BITS-1:0] fs_m1;
  logic [1:0]          cls_status;
  logic [POS_BITS-1:0] cls_start;
  logic [POS_BITS-1:0] cls_end;

  assign is_digit = (item.character >= hbr_pkg::CH_ZERO) &&
                    (item.character <= hbr_pkg::CH_NINE);
  assign is_space = (item.character == hbr_pkg::CH_SPACE) ||
                    (item.character == hbr_pkg::CH_TAB);

  // Decimal accumulate with saturation at the all-ones position value.
  assign acc_in   = (phase_r == PH_START) ? first_r : second_r;
  assign acc_ext  = ACC_W'(acc_in);
  assign acc_wide = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(item.character[3:0]);
  assign acc_out  = (acc_wide[ACC_W-1:POS_BITS] != 4'd0) ? {POS_BITS{1'b1}}
                                                          : acc_wide[POS_BITS-1:0];

  assign fs_m1 = (file_size == '0) ? '0 : file_size - POS_BITS'(1);

  always_comb begin
    cls_status = hbr_pkg::ST_OK;
    cls_start  = '0;
    cls_end    = '0;
    if (phase_r == PH_SUFFIX) begin
      if (!digit_seen_r) begin
        cls_status = hbr_pkg::ST_SYNTAX;
      end else if ((second_r == '0) || (file_size == '0)) begin
        cls_status = hbr_pkg::ST_UNSAT;
      end else begin
        cls_start = (second_r >= file_size) ? '0 : file_size - second_r;
        cls_end   = fs_m1;
      end
    end else begin
      if (digit_seen_r && (first_r > second_r)) begin
        cls_status = hbr_pkg::ST_SYNTAX;
      end else if ((file_size == '0) || (first_r >= file_size)) begin
        cls_status = hbr_pkg::ST_UNSAT;
      end else begin
        cls_start = first_r;
        cls_end   = (digit_seen_r && (second_r < fs_m1)) ? second_r : fs_m1;
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    digit_seen_nxt = digit_seen_r;
    list_seen_nxt  = list_seen_r;
    range_seen_nxt = range_seen_r;
    err_nxt        = err_r;
    res_valid      = 1'b0;
    res            = '0;
    res.multipart  = list_seen_r;
    if (step_en) begin
      if (item.kind) begin
        res_valid     = 1'b1;
        res.final_res = 1'b1;
        case (phase_r)
          PH_FAIL: begin
            res.status = err_r;
          end
          PH_SUFFIX, PH_SPAN: begin
            res.status = cls_status;
            if (cls_status == hbr_pkg::ST_OK) begin
              res.range_start = RW'(cls_start);
              res.range_end   = RW'(cls_end);
            end
          end
          default: begin
            res.status = hbr_pkg::ST_NONE;
            if (!range_seen_r) begin
              res.range_end = RW'(fs_m1);
            end
          end
        endcase
        phase_nxt      = PH_START;
        first_nxt      = '0;
        second_nxt     = '0;
        digit_seen_nxt = 1'b0;
        list_seen_nxt  = 1'b0;
        range_seen_nxt = 1'b0;
        err_nxt        = hbr_pkg::ST_OK;
      end else begin
        case (phase_r)
          PH_START: begin
            if (is_digit) begin
              first_nxt      = acc_out;
              digit_seen_nxt = 1'b1;
            end else if (is_space && !digit_seen_r) begin
              phase_nxt = PH_START;
            end else if (item.character == hbr_pkg::CH_DASH) begin
              phase_nxt      = digit_seen_r ? PH_SPAN : PH_SUFFIX;
              digit_seen_nxt = 1'b0;
              second_nxt     = '0;
            end else begin
              phase_nxt = PH_JUNK;
            end
          end
          PH_SUFFIX, PH_SPAN: begin
            if (is_digit) begin
              second_nxt     = acc_out;
              digit_seen_nxt = 1'b1;
            end else if (is_space && !digit_seen_r) begin
              phase_nxt = phase_r;
            end else if (item.character == hbr_pkg::CH_COMMA) begin
              if (cls_status != hbr_pkg::ST_OK) begin
                err_nxt   = cls_status;
                phase_nxt = PH_FAIL;
              end else begin
                res_valid       = 1'b1;
                res.status      = hbr_pkg::ST_OK;
                res.range_start = RW'(cls_start);
                res.range_end   = RW'(cls_end);
                res.multipart   = 1'b1;
                list_seen_nxt   = 1'b1;
                range_seen_nxt  = 1'b1;
                phase_nxt       = PH_START;
                first_nxt       = '0;
                second_nxt      = '0;
                digit_seen_nxt  = 1'b0;
              end
            end else begin
              err_nxt   = hbr_pkg::ST_SYNTAX;
              phase_nxt = PH_FAIL;
            end
          end
          PH_JUNK: begin
            if (item.character == hbr_pkg::CH_DASH) begin
              err_nxt   = hbr_pkg::ST_SYNTAX;
              phase_nxt = PH_FAIL;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      first_r      <= '0;
      second_r     <= '0;
      digit_seen_r <= 1'b0;
      list_seen_r  <= 1'b0;
      range_seen_r <= 1'b0;
      err_r        <= hbr_pkg::ST_OK;
    end else begin
      phase_r      <= phase_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      digit_seen_r <= digit_seen_nxt;
      list_seen_r  <= list_seen_nxt;
      range_seen_r <= range_seen_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

// ----- rtl/core/hbr_out_reg.sv -----
module hbr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hbr_pkg::hbr_res_t res_in,
  input  logic              out_stall,
  output logic              out_valid,
  output hbr_pkg::hbr_res_t res_out
);

  logic              valid_r, valid_nxt;
  hbr_pkg::hbr_res_t res_r, res_nxt;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ----- rtl/core/http_byte_range_parser.sv -----
// Byte-range list parser: takes the text after "bytes=" one character per
// request (in_kind 0) and a closing request (in_kind 1), and checks each
// range against cfg_file_size, which the user must write only while the block
// is idle; the block itself does not enforce this. A valid range is returned
// when its comma arrives; the closing request always returns one final result.
// One request is taken every clock cycle unless in_stall is high; a request
// passes an input register and then the result register. The input
// register also holds one request while a waiting result blocks the output.
module http_byte_range_parser #(
  parameter int POS_BITS = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [47:0] cfg_file_size,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [47:0] out_range_start,
  output logic [47:0] out_range_end,
  output logic        out_multipart,
  output logic        out_final_res
);

  `include "http_byte_range_parser_macros.svh"

  logic [POS_BITS-1:0] file_size_r, file_size_nxt;
  logic                in_v_r, in_v_nxt;
  hbr_pkg::hbr_item_t  item_r, item_nxt;
  logic                accept;
  logic                advance;
  logic                res_valid;
  hbr_pkg::hbr_res_t   res;
  hbr_pkg::hbr_res_t   res_q;

  assign advance  = in_v_r && (!out_valid || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    file_size_nxt = cfg_we ? POS_BITS'(cfg_file_size) : file_size_r;
    in_v_nxt      = accept || (in_v_r && !advance);
    item_nxt      = item_r;
    if (accept) begin
      item_nxt.kind      = in_kind;
      item_nxt.character = in_character;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
      in_v_r      <= 1'b0;
    end else begin
      file_size_r <= file_size_nxt;
      in_v_r      <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  hbr_parse #(
    .POS_BITS (POS_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (item_r),
    .file_size (file_size_r),
    .res_valid (res_valid),
    .res       (res)
  );

  hbr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_status      = res_q.status;
  assign out_range_start = res_q.range_start;
  assign out_range_end   = res_q.range_end;
  assign out_multipart   = res_q.multipart;
  assign out_final_res   = res_q.final_res;

  `HBR_ASSERT_NXT(a_close_gives_final, clk, rst_n, advance && item_r.kind,
    out_valid && out_final_res, "closing request gave no final result")
  `HBR_ASSERT_IMP(a_error_only_final, clk, rst_n,
    out_valid && (out_status != hbr_pkg::ST_OK), out_final_res,
    "error status on a non-final result")
  `HBR_ASSERT_IMP(a_comma_is_multipart, clk, rst_n, out_valid && !out_final_res,
    out_multipart && (out_status == hbr_pkg::ST_OK),
    "comma result without multipart flag")
  `HBR_ASSERT_IMP(a_stall_needs_item, clk, rst_n, in_stall, in_v_r && out_valid,
    "input stalled with no blocking result")

endmodule
